>>> rtl/pst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pst_pkg;
	localparam int MAX_LEN_DEF  = 4096;
	localparam int ALPHABET_DEF = 26;
	localparam int LET_W   = 5;
	localparam int NODE_W  = 13;
	localparam int START_W = 12;
	localparam int LEN_W   = 14;

	typedef struct packed {
		logic [LET_W-1:0] letter;
		logic             first;
	} item_t;

	typedef struct packed {
		logic [NODE_W-1:0]  suffix_node;
		logic [NODE_W-1:0]  suffix_len;
		logic [START_W-1:0] suffix_start;
		logic               is_new;
		logic [NODE_W-1:0]  node_total;
		logic               full_res;
	} result_t;
endpackage
`default_nettype wire

>>> rtl/pst_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module pst_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      dout,
	output logic              empty
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule
`default_nettype wire

>>> rtl/pst_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module pst_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pst_pkg::item_t  in_item,
	input  wire logic            in_empty,
	output logic                 in_pop,
	output pst_pkg::result_t     res,
	input  wire logic            out_full,
	output logic                 out_push
);
	import pst_pkg::*;

	localparam int MAX_LEN  = MAX_LEN_DEF;
	localparam int ALPHABET = ALPHABET_DEF;
	localparam int SLOTS = MAX_LEN + 3;
	localparam int TA_W  = $clog2(MAX_LEN);
	localparam int NA_W  = $clog2(SLOTS);
	localparam int CA_W  = $clog2(SLOTS * ALPHABET);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BEGIN = 4'd1;
	localparam logic [3:0] S_WRD   = 4'd2;
	localparam logic [3:0] S_WLEN  = 4'd3;
	localparam logic [3:0] S_WCMP  = 4'd4;
	localparam logic [3:0] S_CRD   = 4'd5;
	localparam logic [3:0] S_CCHK  = 4'd6;
	localparam logic [3:0] S_CVER  = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;
	localparam logic [3:0] S_CLR   = 4'd9;

	logic [3:0] state_q;

	logic [LET_W-1:0]   let_q;
	logic [NODE_W-1:0]  pos_q, cnt_q, lsuf_q, lsuf_len_q;
	logic [NODE_W-1:0]  nd_q, look_q, cur_q, cur_link_q, link_q, hit_q;
	logic [LEN_W-1:0]   len_q, cur_len_q;
	logic [CA_W-1:0]    caddr_q, clr_q;
	logic [START_W-1:0] start_q;
	logic               phase_q, new_q, full_q;

	// memories
	logic [LET_W-1:0]  text_mem [MAX_LEN];
	logic [LEN_W-1:0]  len_mem  [SLOTS];
	logic [NODE_W-1:0] link_mem [SLOTS];
	logic [NODE_W-1:0] par_mem  [SLOTS];
	logic [LET_W-1:0]  lt_mem   [SLOTS];
	logic [NODE_W-1:0] child_mem[SLOTS * ALPHABET];

	logic [LET_W-1:0]  text_rd, lt_rd;
	logic [LEN_W-1:0]  len_rd;
	logic [NODE_W-1:0] link_rd, par_rd, child_rd;

	logic              text_we, node_we, link_we, child_we;
	logic [TA_W-1:0]   text_ra;
	logic [NA_W-1:0]   node_ra, node_wa, link_wa;
	logic [CA_W-1:0]   child_wa;
	logic [NODE_W-1:0] link_wd, child_wd, nw;
	logic [LEN_W-1:0]  lenv, nlen;
	logic [NODE_W-1:0] linkv;
	logic [LEN_W:0]    idx;
	logic              valid, room;
	logic [NODE_W+LET_W:0] cprod;

	assign nw    = cnt_q + NODE_W'(1);
	assign nlen  = cur_len_q + LEN_W'(2);
	assign lenv  = (nd_q == NODE_W'(1)) ? '1 :
	               (nd_q <= NODE_W'(2)) ? '0 : len_rd;
	assign linkv = (nd_q <= NODE_W'(2)) ? NODE_W'(1) : link_rd;
	assign idx   = {2'b00, pos_q} - (LEN_W+1)'(1) - {lenv[LEN_W-1], lenv};
	assign valid = (hit_q > NODE_W'(2)) && (hit_q <= cnt_q) &&
	               (par_rd == look_q) && (lt_rd == let_q);
	assign room  = ({1'b0, cnt_q} < (NODE_W+1)'(MAX_LEN + 2));
	assign cprod = (NODE_W+LET_W+1)'(nd_q) * (NODE_W+LET_W+1)'(ALPHABET) +
	               (NODE_W+LET_W+1)'(let_q);

	always_comb begin
		text_we  = (state_q == S_BEGIN) && !({1'b0, pos_q} >= (NODE_W+1)'(MAX_LEN));
		text_ra  = idx[TA_W-1:0];
		node_ra  = (state_q == S_CCHK) ? NA_W'(child_rd) : NA_W'(nd_q);
		node_we  = (state_q == S_CVER) && !phase_q && !valid && room;
		node_wa  = NA_W'(nw);
		child_we = node_we || (state_q == S_CLR);
		child_wa = (state_q == S_CLR) ? clr_q : caddr_q;
		child_wd = (state_q == S_CLR) ? '0 : nw;
		link_we  = 1'b0;
		link_wa  = NA_W'(nw);
		link_wd  = NODE_W'(2);
		if (state_q == S_CVER) begin
			if (phase_q) begin
				link_we = 1'b1;
				link_wa = NA_W'(cnt_q);
				link_wd = valid ? hit_q : '0;
			end else begin
				link_we = node_we && (nlen == LEN_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_we) text_mem[TA_W'(pos_q)] <= let_q;
		text_rd <= text_mem[text_ra];
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			len_mem[node_wa] <= nlen;
			par_mem[node_wa] <= cur_q;
			lt_mem[node_wa]  <= let_q;
		end
		len_rd <= len_mem[node_ra];
		par_rd <= par_mem[node_ra];
		lt_rd  <= lt_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		link_rd <= link_mem[NA_W'(nd_q)];
	end

	always_ff @(posedge clk) begin
		if (child_we) child_mem[child_wa] <= child_wd;
		child_rd <= child_mem[caddr_q];
	end

	assign in_pop   = (state_q == S_IDLE) && !in_empty;
	assign out_push = (state_q == S_EMIT) && !out_full;

	always_comb begin
		res.suffix_node  = lsuf_q;
		res.suffix_len   = lsuf_len_q;
		res.suffix_start = start_q;
		res.is_new       = new_q;
		res.node_total   = cnt_q;
		res.full_res     = full_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			pos_q      <= '0;
			cnt_q      <= NODE_W'(2);
			lsuf_q     <= NODE_W'(2);
			lsuf_len_q <= '0;
			phase_q    <= 1'b0;
			new_q      <= 1'b0;
			full_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CA_W'(1);
					if (clr_q == CA_W'(SLOTS * ALPHABET - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (!in_empty) begin
						start_q <= '0;
						if (in_item.first) begin
							pos_q      <= '0;
							cnt_q      <= NODE_W'(2);
							lsuf_q     <= NODE_W'(2);
							lsuf_len_q <= '0;
						end
						state_q <= S_BEGIN;
					end
				end
				S_BEGIN: begin
					new_q   <= 1'b0;
					phase_q <= 1'b0;
					nd_q    <= lsuf_q;
					full_q  <= !text_we;
					state_q <= text_we ? S_WRD : S_EMIT;
				end
				S_WRD: state_q <= S_WLEN;
				S_WLEN: begin
					len_q  <= lenv;
					link_q <= linkv;
					if (idx[LEN_W] && nd_q != NODE_W'(1)) begin
						nd_q    <= (linkv == '0) ? NODE_W'(1) : linkv;
						state_q <= S_WRD;
					end else begin
						state_q <= S_WCMP;
					end
				end
				S_WCMP: begin
					if (text_rd == let_q || nd_q == NODE_W'(1)) begin
						look_q  <= nd_q;
						caddr_q <= CA_W'(cprod);
						if (!phase_q) begin
							cur_q      <= nd_q;
							cur_len_q  <= len_q;
							cur_link_q <= link_q;
						end
						state_q <= S_CRD;
					end else begin
						nd_q    <= (link_q == '0) ? NODE_W'(1) : link_q;
						state_q <= S_WRD;
					end
				end
				S_CRD: state_q <= S_CCHK;
				S_CCHK: begin
					hit_q   <= child_rd;
					state_q <= S_CVER;
				end
				S_CVER: begin
					state_q <= S_EMIT;
					if (!phase_q) begin
						if (valid) begin
							lsuf_q     <= hit_q;
							lsuf_len_q <= NODE_W'(len_rd);
						end else if (room) begin
							cnt_q      <= nw;
							new_q      <= 1'b1;
							lsuf_q     <= nw;
							lsuf_len_q <= NODE_W'(nlen);
							start_q    <= START_W'(pos_q - NODE_W'(nlen) + NODE_W'(1));
							if (nlen != LEN_W'(1)) begin
								nd_q    <= (cur_link_q == '0) ? NODE_W'(1) : cur_link_q;
								phase_q <= 1'b1;
								state_q <= S_WRD;
							end
						end
					end
				end
				S_EMIT: begin
					if (!out_full) begin
						if (!full_q) pos_q <= pos_q + NODE_W'(1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && !in_empty) begin
			let_q <= in_item.letter;
		end
	end
endmodule
`default_nettype wire

>>> rtl/palindromic_suffix_tree_builder_core.sv
// Palindromic tree (eertree) builder: one lowercase letter per pushed word, one
// result word per letter. A two-word input queue takes letters while the walk engine
// works. After reset the engine zeroes all 106574 entries of the child table, one
// entry per cycle, before it takes the first letter. For each letter it walks suffix
// links from the longest suffix until one extends, then reads and checks the child;
// a letter that creates a node longer than one adds a second walk and child lookup
// for its suffix link. A letter that meets a full text skips the walk. A full result
// queue stalls the engine further.
// first=1 restarts the string without a clearing pass: stale child entries are
// rejected by checking the stored parent and letter of the node they name.
`timescale 1ns / 1ps
`default_nettype none
module palindromic_suffix_tree_builder_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [pst_pkg::LET_W-1:0]   letter,
	input  wire logic                        first,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [pst_pkg::NODE_W-1:0]       suffix_node,
	output logic [pst_pkg::NODE_W-1:0]       suffix_len,
	output logic [pst_pkg::START_W-1:0]      suffix_start,
	output logic                             is_new,
	output logic [pst_pkg::NODE_W-1:0]       node_total,
	output logic                             full_res
);
	import pst_pkg::*;

	item_t   in_w, eng_item;
	result_t eng_res, out_res;
	logic    in_empty, in_pop, out_full, out_push;

	always_comb begin
		in_w.first  = first;
		in_w.letter = (letter >= LET_W'(ALPHABET_DEF)) ? LET_W'(ALPHABET_DEF - 1) : letter;
	end

	pst_fifo #(.W($bits(item_t))) u_inq (
		.clk(clk), .arst_n(arst_n),
		.push(push), .din(in_w), .full(full),
		.pop(in_pop), .dout(eng_item), .empty(in_empty)
	);

	pst_engine u_eng (
		.clk(clk), .arst_n(arst_n),
		.in_item(eng_item), .in_empty(in_empty), .in_pop(in_pop),
		.res(eng_res), .out_full(out_full), .out_push(out_push)
	);

	pst_fifo #(.W($bits(result_t))) u_outq (
		.clk(clk), .arst_n(arst_n),
		.push(out_push), .din(eng_res), .full(out_full),
		.pop(pop), .dout(out_res), .empty(empty)
	);

	assign suffix_node  = out_res.suffix_node;
	assign suffix_len   = out_res.suffix_len;
	assign suffix_start = out_res.suffix_start;
	assign is_new       = out_res.is_new;
	assign node_total   = out_res.node_total;
	assign full_res     = out_res.full_res;
endmodule
`default_nettype wire

>>> rtl/pst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pst_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [12:0] suffix_node,
	input wire logic [11:0] suffix_start,
	input wire logic        is_new,
	input wire logic [12:0] node_total,
	input wire logic        full_res
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(suffix_node))
		else $error("result changed while stalled");
	a_new_is_top: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && is_new |-> suffix_node == node_total)
		else $error("new node is not the last allocated");
	a_full_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && full_res |-> !is_new && suffix_start == 12'd0)
		else $error("ignored letter reported a node");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> node_total >= 13'd2 && suffix_node <= node_total)
		else $error("node index out of range");
endmodule

bind palindromic_suffix_tree_builder_core pst_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.suffix_node(suffix_node), .suffix_start(suffix_start), .is_new(is_new),
	.node_total(node_total), .full_res(full_res)
);
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import pst_pkg::*;

	localparam int TXT_CAP   = 4096;
	localparam int SIGMA     = 26;
	localparam int SLOTS     = TXT_CAP + 3;
	localparam int WDOG_LIM  = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [LET_W-1:0] letter = '0;
	logic first = 1'b0;
	logic full, empty, is_new, full_res;
	logic [NODE_W-1:0] suffix_node, suffix_len, node_total;
	logic [START_W-1:0] suffix_start;

	palindromic_suffix_tree_builder_core uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.letter(letter), .first(first), .empty(empty), .pop(pop),
		.suffix_node(suffix_node), .suffix_len(suffix_len),
		.suffix_start(suffix_start), .is_new(is_new),
		.node_total(node_total), .full_res(full_res)
	);

	always #1 clk = ~clk;

	// tree mirror
	logic [LET_W-1:0] txt [TXT_CAP];
	int nlen [SLOTS];
	int nlink [SLOTS];
	int kid [SLOTS*SIGMA];
	int txt_pos, n_nodes, longest;

	item_t   letters_q [$];
	result_t tree_q [$];
	int errors = 0;
	int n_new = 0, n_full = 0, n_strings = 0, n_checked = 0;
	bit calm = 1'b0;
	int in_gap = 0, out_gap = 0, quiet = 0;

	function automatic void tree_clear();
		int rows;
		rows = n_nodes + 1;
		if (rows > SLOTS) rows = SLOTS;
		for (int i = 0; i < rows*SIGMA; i++) kid[i] = 0;
		nlen[0] = 0; nlink[0] = 1;
		nlen[1] = -1; nlink[1] = 1;
		nlen[2] = 0; nlink[2] = 1;
		txt_pos = 0; n_nodes = 2; longest = 2;
	endfunction

	function automatic bit mirrors(int nd, int pos, int sym);
		int idx;
		idx = pos - 1 - nlen[nd];
		if (idx < 0 || idx >= TXT_CAP) return 1'b0;
		return int'(txt[idx]) == sym;
	endfunction

	function automatic int link_walk(int nd, int pos, int sym);
		int steps;
		steps = 0;
		while (!mirrors(nd, pos, sym)) begin
			if (nd == 1 || steps >= SLOTS) return 1;
			nd = nlink[nd];
			if (nd == 0 || nd >= SLOTS) return 1;
			steps++;
		end
		return nd;
	endfunction

	function automatic result_t eertree_add(item_t it);
		result_t r;
		int sym, pos, cur, hit, nw, len, lk;
		r = '0;
		sym = int'(it.letter);
		if (sym >= SIGMA) sym = SIGMA - 1;
		if (it.first) tree_clear();
		if (txt_pos >= TXT_CAP) begin
			r.full_res = 1'b1;
			n_full++;
		end else begin
			pos = txt_pos;
			txt[pos] = LET_W'(sym);
			cur = link_walk(longest, pos, sym);
			hit = kid[cur*SIGMA + sym];
			if (hit != 0) begin
				longest = hit;
			end else if (n_nodes + 1 < SLOTS) begin
				nw = n_nodes + 1;
				len = nlen[cur] + 2;
				n_nodes = nw;
				nlen[nw] = len;
				kid[cur*SIGMA + sym] = nw;
				r.suffix_start = START_W'(pos - len + 1);
				r.is_new = 1'b1;
				n_new++;
				if (len == 1) begin
					nlink[nw] = 2;
				end else begin
					lk = link_walk(nlink[cur], pos, sym);
					nlink[nw] = kid[lk*SIGMA + sym];
				end
				longest = nw;
			end
			txt_pos = pos + 1;
		end
		r.suffix_node = NODE_W'(longest);
		r.suffix_len = NODE_W'(nlen[longest]);
		r.node_total = NODE_W'(n_nodes);
		return r;
	endfunction

	function automatic void add_word(int sym, bit f);
		item_t it;
		it.letter = LET_W'(sym);
		it.first = f;
		letters_q = {letters_q, it};
	endfunction

	// driver
	always @(posedge clk) begin
		bit nx_push;
		nx_push = 1'b0;
		if (push && !full) begin
			tree_q = {tree_q, eertree_add(letters_q[0])};
			void'(letters_q.pop_front());
		end
		if (letters_q.size() < 150) calm <= 1'b1;
		if (in_gap > 0) begin
			in_gap <= in_gap - 1;
		end else if (arst_n && letters_q.size() > 0) begin
			if (!calm && $urandom_range(0, 11) == 0) begin
				in_gap <= $urandom_range(1, 17);
			end else begin
				nx_push = 1'b1;
				letter <= letters_q[0].letter;
				first <= letters_q[0].first;
			end
		end
		push <= nx_push;
	end

	// monitor
	always @(posedge clk) begin
		result_t w;
		bit nx_pop;
		nx_pop = 1'b0;
		if (pop && !empty) begin
			quiet <= 0;
			if (tree_q.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				w = tree_q.pop_front();
				n_checked++;
				if (suffix_node !== w.suffix_node) begin
					$error("suffix_node exp %0d got %0d", w.suffix_node, suffix_node);
					errors++;
				end
				if (suffix_len !== w.suffix_len) begin
					$error("suffix_len exp %0d got %0d", w.suffix_len, suffix_len);
					errors++;
				end
				if (suffix_start !== w.suffix_start) begin
					$error("suffix_start exp %0d got %0d", w.suffix_start, suffix_start);
					errors++;
				end
				if (is_new !== w.is_new) begin
					$error("is_new exp %0d got %0d", w.is_new, is_new);
					errors++;
				end
				if (node_total !== w.node_total) begin
					$error("node_total exp %0d got %0d", w.node_total, node_total);
					errors++;
				end
				if (full_res !== w.full_res) begin
					$error("full_res exp %0d got %0d", w.full_res, full_res);
					errors++;
				end
			end
		end else if (push && !full) begin
			quiet <= 0;
		end else if (arst_n) begin
			quiet <= quiet + 1;
			if (quiet >= WDOG_LIM) begin
				$display("TEST FAILED");
				$finish;
			end
		end
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
		end else if (arst_n) begin
			if (!calm && $urandom_range(0, 11) == 0) out_gap <= $urandom_range(1, 17);
			else nx_pop = 1'b1;
		end
		pop <= nx_pop;
	end

	initial begin
		int slen, span;
		n_nodes = 2;
		tree_clear();
		// directed words for the roots, several letter codes incl. out-of-range, and restarts
		add_word(0, 1'b1);
		add_word(0, 1'b0);
		add_word(1, 1'b0);
		add_word(0, 1'b0);
		add_word(31, 1'b0);
		add_word(25, 1'b0);
		add_word(26, 1'b0);
		add_word(1, 1'b0);
		add_word(0, 1'b0);
		add_word(21, 1'b1);
		add_word(10, 1'b0);
		add_word(21, 1'b0);
		add_word(15, 1'b1);
		n_strings = 3;
		while (letters_q.size() < 1900) begin
			slen = $urandom_range(1, 60);
			span = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(1, 3);
			n_strings++;
			for (int i = 0; i < slen; i++)
				add_word($urandom_range(0, span - 1), i == 0 || $urandom_range(0, 99) == 0);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (letters_q.size() == 0 && tree_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("checked %0d result words over %0d strings", n_checked, n_strings);
		$display("%0d nodes created, %0d letters hit a full text", n_new, n_full);
		if (errors == 0 && tree_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
